// ----- hdl/cht_pkg.sv -----
// Shared types and constants for the chained hash table.
// Request/response structs, action and status codes, fixed field widths.
// No dependencies.
package cht_pkg;

    // Fixed field widths
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned SLOT_W   = 7;
    localparam int unsigned BUCKET_W = 6;
    localparam int unsigned COMP_W   = 9;

    localparam logic [COMP_W-1:0] COMP_MAX   = '1;
    localparam logic [SLOT_W-1:0] SLOT_RESET = 7'd37;

    // Remainder unit: quotient bits retired per cycle
    localparam int unsigned DIV_BITS   = 4;
    localparam int unsigned DIV_STEPS  = KEY_W / DIV_BITS;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_SEARCH = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FOUND    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        action_t            action;
        logic [KEY_W-1:0]   key;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [BUCKET_W-1:0]  bucket;
        logic [COMP_W-1:0]    comparisons;
    } rsp_t;

endpackage

// ----- hdl/chained_hash_table.sv -----
// Chained hash table, division hash, tail append, head-first search.
// Bucket table and node pool in synchronous memories; depends on cht_pkg.
//
// Channel   Dir  Handshake                    Payload
// request   in   start & !busy                req (req_t: action, key)
// response  out  done, one cycle, no stall    rsp (rsp_t: status, bucket, comparisons)
// config    in   cfg_we                       cfg_wdata (slot count)
//
// Remainder unit retires 4 key bits a cycle. Insert: the bucket entry is read,
// then the new node and the bucket entry are written; when the bucket already
// has a chain, a tail link write follows. Search: the walk reads one node a
// cycle from the node memories, address from the link read. After reset a
// clearing pass writes every bucket entry, busy high. Responses cannot be
// stalled; one request is in flight at a time.
module chained_hash_table
    import cht_pkg::*;
#(
    parameter int unsigned MAX_BUCKETS = 64,
    parameter int unsigned NODE_COUNT  = 256
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  req_t              req,
    output logic              done,
    output rsp_t              rsp,
    input  logic              cfg_we,
    input  logic [SLOT_W-1:0] cfg_wdata
);

    localparam int unsigned AW = $clog2(NODE_COUNT);
    localparam int unsigned UW = $clog2(NODE_COUNT + 1);
    localparam int unsigned BW = $clog2(MAX_BUCKETS);
    localparam int unsigned SLOT_CAP = (MAX_BUCKETS < 127) ? MAX_BUCKETS : 127;
    localparam logic [SLOT_W-1:0] SLOT_CAP_V = SLOT_W'(SLOT_CAP);
    localparam logic [BW-1:0]     CLR_LAST   = BW'(MAX_BUCKETS - 1);
    localparam logic [UW-1:0]     POOL_FULL  = UW'(NODE_COUNT);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_DIV   = 6'b000100,
        S_HEAD  = 6'b001000,
        S_LINK  = 6'b010000,
        S_WALK  = 6'b100000
    } state_t;

    typedef struct packed {
        logic          valid;
        logic [AW-1:0] first;
        logic [AW-1:0] last;
    } head_t;

    typedef struct packed {
        logic          valid;
        logic [AW-1:0] ptr;
    } link_t;

    // Memories
    head_t            head_mem [MAX_BUCKETS];
    logic [KEY_W-1:0] key_mem  [NODE_COUNT];
    link_t            link_mem [NODE_COUNT];

    // Control registers
    state_t            state_reg, state_next;
    logic [BW-1:0]     clr_reg, clr_next;
    logic [UW-1:0]     used_reg, used_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;

    // Payload registers
    action_t           action_reg, action_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [KEY_W-1:0]  quo_reg, quo_next;
    logic [SLOT_W-1:0] rem_reg, rem_next;
    logic [SLOT_W-1:0] div_reg, div_next;
    logic [BW-1:0]     bucket_reg, bucket_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [AW-1:0]     new_reg, new_next;
    logic [COMP_W-1:0] comps_reg, comps_next;
    rsp_t              rsp_reg, rsp_next;

    // Memory read data
    head_t             head_rd_reg;
    logic [KEY_W-1:0]  key_rd_reg;
    link_t             link_rd_reg;

    // Memory port controls
    logic              head_we, head_re;
    logic [BW-1:0]     head_waddr, head_raddr;
    head_t             head_wdata;
    logic              key_we, link_we, node_re;
    logic [AW-1:0]     key_waddr, link_waddr, node_raddr;
    logic [KEY_W-1:0]  key_wdata;
    link_t             link_wdata;

    // Datapath helpers
    logic [SLOT_W-1:0] slot_eff;
    logic [SLOT_W:0]   step_r;
    logic [KEY_W-1:0]  step_q;
    logic [SLOT_W-1:0] step_rem;
    logic [AW-1:0]     node_new;
    logic [COMP_W-1:0] comps_inc;

    // Divisor clamped to 1..SLOT_CAP (MAX_BUCKETS, but at most 127)
    always_comb
    begin
        if (slot_reg == '0)
            slot_eff = SLOT_W'(1);
        else if (slot_reg > SLOT_CAP_V)
            slot_eff = SLOT_CAP_V;
        else
            slot_eff = slot_reg;
    end

    // Restoring remainder, DIV_BITS key bits per cycle; remainder stays below divisor
    always_comb
    begin
        step_r = {1'b0, rem_reg};
        step_q = quo_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            step_r = {step_r[SLOT_W-1:0], step_q[KEY_W-1]};
            step_q = {step_q[KEY_W-2:0], 1'b0};
            if (step_r >= {1'b0, div_reg})
                step_r = step_r - {1'b0, div_reg};
        end
        step_rem = step_r[SLOT_W-1:0];
    end

    assign node_new  = used_reg[AW-1:0];
    assign comps_inc = (comps_reg == COMP_MAX) ? comps_reg : comps_reg + 1'b1;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        used_next   = used_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        action_next = action_reg;
        key_next    = key_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        bucket_next = bucket_reg;
        tail_next   = tail_reg;
        new_next    = new_reg;
        comps_next  = comps_reg;
        rsp_next    = rsp_reg;

        head_we    = 1'b0;
        head_re    = 1'b0;
        head_waddr = bucket_reg;
        head_raddr = bucket_reg;
        head_wdata = '0;
        key_we     = 1'b0;
        key_waddr  = node_new;
        key_wdata  = key_reg;
        link_we    = 1'b0;
        link_waddr = node_new;
        link_wdata = '0;
        node_re    = 1'b0;
        node_raddr = link_rd_reg.ptr;

        case (state_reg)
            S_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                if (clr_reg == CLR_LAST)
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + 1'b1;
            end

            S_IDLE:
            begin
                if (start)
                begin
                    action_next = req.action;
                    key_next    = req.key;
                    quo_next    = req.key;
                    rem_next    = '0;
                    div_next    = slot_eff;
                    cnt_next    = '0;
                    comps_next  = '0;
                    state_next  = S_DIV;
                end
            end

            S_DIV:
            begin
                quo_next = step_q;
                rem_next = step_rem;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    bucket_next = BW'(step_rem);
                    head_re     = 1'b1;
                    head_raddr  = BW'(step_rem);
                    state_next  = S_HEAD;
                end
            end

            S_HEAD:
            begin
                rsp_next.bucket      = BUCKET_W'(rem_reg);
                rsp_next.comparisons = '0;
                if (action_reg == ACT_INSERT)
                begin
                    if (used_reg == POOL_FULL)
                    begin
                        rsp_next.status = ST_FULL;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        // new node: key, no successor
                        key_we    = 1'b1;
                        link_we   = 1'b1;
                        used_next = used_reg + 1'b1;
                        new_next  = node_new;
                        head_we   = 1'b1;
                        if (!head_rd_reg.valid)
                        begin
                            head_wdata      = '{valid: 1'b1, first: node_new, last: node_new};
                            rsp_next.status = ST_INSERTED;
                            done_next       = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            head_wdata = '{valid: 1'b1, first: head_rd_reg.first,
                                           last: node_new};
                            tail_next  = head_rd_reg.last;
                            state_next = S_LINK;
                        end
                    end
                end
                else
                begin
                    if (!head_rd_reg.valid)
                    begin
                        rsp_next.status = ST_NOTFOUND;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        node_re    = 1'b1;
                        node_raddr = head_rd_reg.first;
                        state_next = S_WALK;
                    end
                end
            end

            S_LINK:
            begin
                // hook the new node behind the old tail
                link_we         = 1'b1;
                link_waddr      = tail_reg;
                link_wdata      = '{valid: 1'b1, ptr: new_reg};
                rsp_next.status = ST_INSERTED;
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end

            S_WALK:
            begin
                comps_next           = comps_inc;
                rsp_next.comparisons = comps_inc;
                if (key_rd_reg == key_reg)
                begin
                    rsp_next.status = ST_FOUND;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (link_rd_reg.valid)
                begin
                    node_re    = 1'b1;
                    node_raddr = link_rd_reg.ptr;
                end
                else
                begin
                    rsp_next.status = ST_NOTFOUND;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            used_reg  <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            slot_reg  <= SLOT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            used_reg  <= used_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            if (cfg_we)
                slot_reg <= cfg_wdata;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        key_reg    <= key_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        bucket_reg <= bucket_next;
        tail_reg   <= tail_next;
        new_reg    <= new_next;
        comps_reg  <= comps_next;
        rsp_reg    <= rsp_next;
    end

    // Bucket table
    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_waddr] <= head_wdata;
        if (head_re)
            head_rd_reg <= head_mem[head_raddr];
    end

    // Node pool: keys
    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[key_waddr] <= key_wdata;
        if (node_re)
            key_rd_reg <= key_mem[node_raddr];
    end

    // Node pool: links
    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_waddr] <= link_wdata;
        if (node_re)
            link_rd_reg <= link_mem[node_raddr];
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ----- hdl/cht_chk.sv -----
// Port-level checker for the chained hash table, bound to the top level.
// Depends on cht_pkg and chained_hash_table.
module cht_chk
    import cht_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input rsp_t              rsp
);

    // an accepted request occupies the block on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // a response is given only once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("response while busy");

    // each response is a single-cycle strobe
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back responses");

    // inserts and pool-full make no comparisons
    a_insert_comps: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status == ST_INSERTED || rsp.status == ST_FULL))
            |-> (rsp.comparisons == '0))
        else $error("insert reported comparisons");

    // a hit needs at least one comparison
    a_found_comps: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == ST_FOUND) |-> (rsp.comparisons != '0))
        else $error("hit with zero comparisons");

endmodule

bind chained_hash_table cht_chk u_cht_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .rsp       (rsp)
);
